[design/c2s_pkg.sv]
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared types and constants for the cube-to-sphere point map.
// ----------------------------------------------------------------------------
`default_nettype none

package c2s_pkg;

  localparam int F       = 14;           // fraction bits of coordinates
  localparam int MAG_W   = F + 1;        // magnitude up to ONE
  localparam int ROOT_W  = F + 1;        // root / length / quotient width
  localparam int REM_W   = 2 * F + 2;    // remainder width in root and divide cells
  localparam int SC_W    = 23;           // sphere magnitude
  localparam int SPH_W   = 24;
  localparam int NRM_W   = 16;
  localparam int RAD_W   = 16;
  localparam int NSTEPS  = ROOT_W;       // cells per chain

  localparam logic [MAG_W-1:0] ONE        = MAG_W'(1) << F;
  localparam logic [SC_W-1:0]  SPHERE_MAX = {SC_W{1'b1}};
  localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(256);
  // floor(n/3) == (n * RECIP3) >> 17 for n < 2^17
  localparam logic [15:0]      RECIP3     = 16'd43691;

  typedef logic [MAG_W-1:0]  mag_t;
  typedef logic [ROOT_W-1:0] root_t;
  typedef logic [REM_W-1:0]  rem_t;
  typedef logic [SC_W-1:0]   sc_t;

  typedef struct packed {
    logic [2:0] neg;
    mag_t [2:0] mag;
    mag_t [2:0] sq;
    mag_t [2:0] m;
    sc_t  [2:0] sc;
  } side_t;

endpackage

`default_nettype wire

[design/c2s_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// c2s_sqrt_cell
// One digit of a restoring square root: tries bit K of the root.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_sqrt_cell #(
  parameter int K = 0
) (
  input  wire             clk,
  input  wire             en,
  input  c2s_pkg::rem_t   rem_in,
  input  c2s_pkg::root_t  root_in,
  output c2s_pkg::rem_t   rem_out,
  output c2s_pkg::root_t  root_out
);

  c2s_pkg::rem_t trial;

  // (root + 2^K)^2 - root^2
  assign trial = (c2s_pkg::rem_t'(root_in) << (K + 1)) + (c2s_pkg::rem_t'(1) << (2 * K));

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_in >= trial) begin
        rem_out  <= rem_in - trial;
        root_out <= root_in | (c2s_pkg::root_t'(1) << K);
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in;
      end
    end
  end

endmodule

`default_nettype wire

[design/c2s_div_cell.sv]
// ----------------------------------------------------------------------------
// c2s_div_cell
// One step of a restoring divider: decides quotient bit K.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_div_cell #(
  parameter int K = 0
) (
  input  wire             clk,
  input  wire             en,
  input  c2s_pkg::rem_t   rem_in,
  input  c2s_pkg::root_t  q_in,
  input  c2s_pkg::root_t  den_in,
  output c2s_pkg::rem_t   rem_out,
  output c2s_pkg::root_t  q_out,
  output c2s_pkg::root_t  den_out
);

  c2s_pkg::rem_t trial;

  assign trial = c2s_pkg::rem_t'(den_in) << K;

  always_ff @(posedge clk) begin
    if (en) begin
      den_out <= den_in;
      if (rem_in >= trial) begin
        rem_out <= rem_in - trial;
        q_out   <= q_in | (c2s_pkg::root_t'(1) << K);
      end else begin
        rem_out <= rem_in;
        q_out   <= q_in;
      end
    end
  end

endmodule

`default_nettype wire

[design/cube_to_sphere_point_map.sv]
// ----------------------------------------------------------------------------
// cube_to_sphere_point_map
// Maps a cube surface point onto a sphere of configured radius, with normal.
// ----------------------------------------------------------------------------
// Fully pipelined: one point per cycle. The pipe holds three chains
// of 15 one-bit cells each: the root of the
// map factor, the length of the mapped point and the normal divide. The
// whole pipe stalls together while a result waits with out_ready low.
// radius is sampled mid-pipe, so write it only while the block is empty.
`default_nettype none

module cube_to_sphere_point_map (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_wr_en,
  input  wire  [15:0]        cfg_wr_data,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  signed [15:0] cube_x,
  input  wire  signed [15:0] cube_y,
  input  wire  signed [15:0] cube_z,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [23:0] sphere_x,
  output logic signed [23:0] sphere_y,
  output logic signed [23:0] sphere_z,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic               degenerate
);

  localparam int N    = c2s_pkg::NSTEPS;
  localparam int S_P  = 1;
  localparam int S_A  = 2;
  localparam int S_R0 = S_A + 1;
  localparam int S_M  = S_R0 + N;
  localparam int S_SC = S_M + 1;
  localparam int S_SU = S_SC + 1;
  localparam int S_L0 = S_SU + 1;
  localparam int S_D0 = S_L0 + N;
  localparam int S_O  = S_D0 + N;
  localparam int NST  = S_O + 1;

  logic [c2s_pkg::RAD_W-1:0] radius;
  logic                      en;
  logic [NST-1:0]            vld;
  c2s_pkg::side_t            side [NST];
  c2s_pkg::side_t            side_m, side_sc;

  assign en       = out_ready || !out_valid;
  assign in_ready = en;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= c2s_pkg::RADIUS_RST;
    end else if (cfg_wr_en) begin
      radius <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // ---- clamp and square ----
  logic signed [15:0] cin [3];
  c2s_pkg::side_t     side0;
  logic [2*c2s_pkg::MAG_W-1:0] sqp [3];

  assign cin[0] = cube_x;
  assign cin[1] = cube_y;
  assign cin[2] = cube_z;

  always_comb begin
    side0 = '0;
    for (int i = 0; i < 3; i++) begin
      if (cin[i] > 16'sd16384) begin
        side0.neg[i] = 1'b0;
        side0.mag[i] = c2s_pkg::ONE;
      end else if (cin[i] < -16'sd16384) begin
        side0.neg[i] = 1'b1;
        side0.mag[i] = c2s_pkg::ONE;
      end else begin
        side0.neg[i] = cin[i][15];
        side0.mag[i] = cin[i][15] ? c2s_pkg::mag_t'(-cin[i]) : c2s_pkg::mag_t'(cin[i]);
      end
      sqp[i] = side0.mag[i] * side0.mag[i];
      side0.sq[i] = c2s_pkg::mag_t'(sqp[i] >> c2s_pkg::F);
    end
  end

  // ---- cross terms, root argument ----
  c2s_pkg::mag_t p   [3];
  c2s_pkg::mag_t arg [3];
  logic [2*c2s_pkg::MAG_W-1:0] pp [3];
  logic signed [18:0] num [3];
  logic [15:0]        half [3];
  logic [31:0]        divp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pp[i] = side[0].sq[(i + 1) % 3] * side[0].sq[(i + 2) % 3];
      num[i] = 19'sd6 * $signed({4'd0, c2s_pkg::ONE})
             + 19'sd2 * $signed({4'd0, p[i]})
             - 19'sd3 * $signed({4'd0, side[S_P].sq[(i + 1) % 3]})
             - 19'sd3 * $signed({4'd0, side[S_P].sq[(i + 2) % 3]});
      half[i] = num[i][18] ? 16'd0 : num[i][16:1];
      divp[i] = half[i] * c2s_pkg::RECIP3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side0;
      for (int i = 1; i < NST; i++) begin
        if (i == S_M) begin
          side[i] <= side_m;
        end else if (i == S_SC) begin
          side[i] <= side_sc;
        end else begin
          side[i] <= side[i-1];
        end
      end
      for (int i = 0; i < 3; i++) begin
        p[i]   <= c2s_pkg::mag_t'(pp[i] >> c2s_pkg::F);
        arg[i] <= c2s_pkg::mag_t'(divp[i] >> 17);
      end
    end
  end

  // ---- map factor root chain, three lanes ----
  c2s_pkg::rem_t  r_rem  [N][3];
  c2s_pkg::root_t r_root [N][3];

  for (genvar j = 0; j < N; j++) begin : g_rchain
    for (genvar l = 0; l < 3; l++) begin : g_lane
      c2s_sqrt_cell #(.K(N - 1 - j)) u_cell (
        .clk      (clk),
        .en       (en),
        .rem_in   (j == 0 ? c2s_pkg::rem_t'(arg[l]) << c2s_pkg::F : r_rem[(j == 0) ? 0 : j-1][l]),
        .root_in  (j == 0 ? '0 : r_root[(j == 0) ? 0 : j-1][l]),
        .rem_out  (r_rem[j][l]),
        .root_out (r_root[j][l])
      );
    end
  end

  // ---- mapped magnitude, scale, squares ----
  logic [2*c2s_pkg::MAG_W-1:0] mp  [3];
  logic [c2s_pkg::MAG_W+c2s_pkg::RAD_W-1:0] scp [3];
  logic [c2s_pkg::SC_W:0] scs [3];
  logic [c2s_pkg::REM_W-1:0] msq [3];
  c2s_pkg::rem_t sum;

  always_comb begin
    side_m  = side[S_M-1];
    side_sc = side[S_SC-1];
    for (int i = 0; i < 3; i++) begin
      mp[i] = side[S_M-1].mag[i] * r_root[N-1][i];
      side_m.m[i] = c2s_pkg::mag_t'(mp[i] >> c2s_pkg::F);
      scp[i] = side[S_SC-1].m[i] * radius;
      scs[i] = (c2s_pkg::SC_W+1)'(scp[i] >> 8);
      side_sc.sc[i] = (scs[i] > {1'b0, c2s_pkg::SPHERE_MAX}) ? c2s_pkg::SPHERE_MAX
                                                             : scs[i][c2s_pkg::SC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        msq[i] <= c2s_pkg::rem_t'(side[S_SC-1].m[i]) * c2s_pkg::rem_t'(side[S_SC-1].m[i]);
      end
      sum <= msq[0] + msq[1] + msq[2];
    end
  end

  // ---- length root chain ----
  c2s_pkg::rem_t  l_rem  [N];
  c2s_pkg::root_t l_root [N];

  for (genvar j = 0; j < N; j++) begin : g_lchain
    c2s_sqrt_cell #(.K(N - 1 - j)) u_cell (
      .clk      (clk),
      .en       (en),
      .rem_in   (j == 0 ? sum : l_rem[(j == 0) ? 0 : j-1]),
      .root_in  (j == 0 ? '0 : l_root[(j == 0) ? 0 : j-1]),
      .rem_out  (l_rem[j]),
      .root_out (l_root[j])
    );
  end

  // ---- normal divide chain, three lanes ----
  c2s_pkg::root_t len0;
  c2s_pkg::rem_t  d_rem [N][3];
  c2s_pkg::root_t d_q   [N][3];
  c2s_pkg::root_t d_den [N][3];

  assign len0 = (l_root[N-1] == '0) ? c2s_pkg::root_t'(1) : l_root[N-1];

  for (genvar j = 0; j < N; j++) begin : g_dchain
    for (genvar l = 0; l < 3; l++) begin : g_lane
      c2s_div_cell #(.K(N - 1 - j)) u_cell (
        .clk     (clk),
        .en      (en),
        .rem_in  (j == 0 ? c2s_pkg::rem_t'(side[S_D0-1].m[l]) << c2s_pkg::F
                         : d_rem[(j == 0) ? 0 : j-1][l]),
        .q_in    (j == 0 ? '0 : d_q[(j == 0) ? 0 : j-1][l]),
        .den_in  (j == 0 ? len0 : d_den[(j == 0) ? 0 : j-1][l]),
        .rem_out (d_rem[j][l]),
        .q_out   (d_q[j][l]),
        .den_out (d_den[j][l])
      );
    end
  end

  // ---- output register ----
  logic                      degen;
  c2s_pkg::root_t            nmag [3];
  logic [c2s_pkg::SPH_W-1:0] sph  [3];
  logic [c2s_pkg::NRM_W-1:0] nrm  [3];

  always_comb begin
    degen = (side[S_O-1].sc[0] == '0) && (side[S_O-1].sc[1] == '0)
         && (side[S_O-1].sc[2] == '0);
    for (int i = 0; i < 3; i++) begin
      nmag[i] = (d_q[N-1][i] > c2s_pkg::ONE) ? c2s_pkg::ONE : d_q[N-1][i];
      sph[i]  = side[S_O-1].neg[i] ? -c2s_pkg::SPH_W'(side[S_O-1].sc[i])
                                   :  c2s_pkg::SPH_W'(side[S_O-1].sc[i]);
      if (degen) begin
        nrm[i] = '0;
      end else begin
        nrm[i] = side[S_O-1].neg[i] ? -c2s_pkg::NRM_W'(nmag[i]) : c2s_pkg::NRM_W'(nmag[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sphere_x   <= sph[0];
      sphere_y   <= sph[1];
      sphere_z   <= sph[2];
      normal_x   <= nrm[0];
      normal_y   <= nrm[1];
      normal_z   <= nrm[2];
      degenerate <= degen;
    end
  end

endmodule

`default_nettype wire
